[rtl/core/usd_pkg.sv]
`default_nettype none

package usd_pkg;

  // One result item as it travels from the parser to the output stage.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_datagram;
    logic       empty_datagram;
  } usd_result_t;

  localparam int unsigned VALUE_W = 62;

  // Bytes that follow the first byte of a QUIC varint, from its two top bits.
  function automatic logic [2:0] varint_extra(input logic [1:0] len_code);
    logic [2:0] extra;
    case (len_code)
      2'd0: extra = 3'd0;
      2'd1: extra = 3'd1;
      2'd2: extra = 3'd3;
      default: extra = 3'd7;
    endcase
    return extra;
  endfunction

endpackage

`default_nettype wire

[rtl/core/usd_ifs.sv]
`default_nettype none

interface usd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface usd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_datagram;
  logic       empty_datagram;

  modport source (output valid, output out_byte, output end_of_datagram,
                  output empty_datagram, input ready);
  modport sink (input valid, input out_byte, input end_of_datagram,
                input empty_datagram, output ready);
endinterface

`default_nettype wire

[rtl/core/usd_front.sv]
`default_nettype none

module usd_front
  import usd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  usd_in_if.sink      bytes,
  input  wire logic   q_full,
  output logic        push,
  output usd_result_t item
);

  localparam logic [1:0] PH_TYPE    = 2'd0;
  localparam logic [1:0] PH_LEN     = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  logic [1:0]         phase, phase_next;
  logic [2:0]         varint_left, varint_left_next;
  logic [VALUE_W-1:0] value_acc, value_acc_next;
  logic               drop_chunk, drop_chunk_next;
  logic [VALUE_W-1:0] payload_left, payload_left_next;

  logic               take;
  logic [1:0]         ph;
  logic [2:0]         vl_upd;
  logic [VALUE_W-1:0] acc_upd;
  logic               vdone;
  logic [VALUE_W-1:0] pl_dec;
  logic               last;
  logic [7:0]         b;

  assign bytes.ready = !q_full;
  assign take        = bytes.valid && !q_full;
  assign b           = bytes.in_byte;
  assign ph          = (phase == 2'd3) ? PH_TYPE : phase;

  always_comb begin
    if (varint_left == 3'd0) begin
      vl_upd  = varint_extra(b[7:6]);
      acc_upd = {{(VALUE_W-6){1'b0}}, b[5:0]};
    end else begin
      vl_upd  = varint_left - 3'd1;
      acc_upd = {value_acc[VALUE_W-9:0], b};
    end
  end

  assign vdone  = (vl_upd == 3'd0);
  assign pl_dec = payload_left - {{(VALUE_W-1){1'b0}}, 1'b1};
  assign last   = (pl_dec == '0);

  always_comb begin
    phase_next        = phase;
    varint_left_next  = varint_left;
    value_acc_next    = value_acc;
    drop_chunk_next   = drop_chunk;
    payload_left_next = payload_left;
    push              = 1'b0;
    item              = '0;
    if (take) begin
      case (ph)
        PH_TYPE: begin
          varint_left_next = vl_upd;
          if (vdone) begin
            drop_chunk_next = (acc_upd != '0);
            value_acc_next  = '0;
            phase_next      = PH_LEN;
          end else begin
            value_acc_next = acc_upd;
            phase_next     = PH_TYPE;
          end
        end
        PH_LEN: begin
          varint_left_next = vl_upd;
          if (vdone) begin
            payload_left_next = acc_upd;
            value_acc_next    = '0;
            if (acc_upd == '0) begin
              // An empty datagram still has to be announced downstream.
              phase_next           = PH_TYPE;
              push                 = !drop_chunk;
              item.end_of_datagram = 1'b1;
              item.empty_datagram  = 1'b1;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end else begin
            value_acc_next = acc_upd;
          end
        end
        default: begin
          payload_left_next    = pl_dec;
          if (last) begin
            phase_next = PH_TYPE;
          end
          push                 = !drop_chunk;
          item.out_byte        = b;
          item.end_of_datagram = last;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_TYPE;
      varint_left  <= 3'd0;
      value_acc    <= '0;
      drop_chunk   <= 1'b0;
      payload_left <= '0;
    end else begin
      phase        <= phase_next;
      varint_left  <= varint_left_next;
      value_acc    <= value_acc_next;
      drop_chunk   <= drop_chunk_next;
      payload_left <= payload_left_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/usd_queue.sv]
`default_nettype none

module usd_queue
  import usd_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire usd_result_t  push_item,
  output logic              full,
  input  wire logic         pop,
  output logic              q_valid,
  output usd_result_t       q_item
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  usd_result_t mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full    = (count == FULL_CNT);
  assign q_valid = (count != '0);
  assign q_item  = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/usd_back.sv]
`default_nettype none

module usd_back
  import usd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         q_valid,
  input  wire usd_result_t  q_item,
  output logic              pop,
  usd_out_if.source         datagrams
);

  logic        out_valid;
  usd_result_t out_item;

  // The output register refills in the same cycle the receiver takes it.
  assign pop = q_valid && (!out_valid || datagrams.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (datagrams.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item <= q_item;
    end
  end

  assign datagrams.valid           = out_valid;
  assign datagrams.out_byte        = out_item.out_byte;
  assign datagrams.end_of_datagram = out_item.end_of_datagram;
  assign datagrams.empty_datagram  = out_item.empty_datagram;

endmodule

`default_nettype wire

[rtl/core/udp_stream_chunk_deframer.sv]
// Chunk deframer for a tunneled UDP byte stream.
// The bytes channel takes one stream byte per request. The stream is a run of
// chunks: a QUIC varint type, a QUIC varint length, then the payload. Payload
// bytes of type-0 chunks leave on the datagrams channel, one per request, with
// end_of_datagram on the last byte; a type-0 chunk of length zero gives one
// request with empty_datagram and end_of_datagram set and out_byte zero.
// Chunks of any other type are consumed without output.
// Throughput is one byte per cycle while the queue is not full.
// A result goes from its accepted byte into a queue entry, then into the output
// register that drives datagrams.
// When the receiver stalls, results collect in a queue of QUEUE_DEPTH entries
// plus the output register; bytes keep being accepted until the queue is
// full, then bytes.ready drops. Bytes of dropped chunks need no room, but
// they wait with all other bytes while the queue is full.
// Synchronous reset returns the parser to expecting a chunk type and empties
// the queue and output register.
`default_nettype none

module udp_stream_chunk_deframer
  import usd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input wire logic  clk,
  input wire logic  rst,
  usd_in_if.sink    bytes,
  usd_out_if.source datagrams
);

  logic        push, q_full, pop, q_valid;
  usd_result_t item, q_item;

  usd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .bytes  (bytes),
    .q_full (q_full),
    .push   (push),
    .item   (item)
  );

  usd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  usd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .datagrams (datagrams)
  );

endmodule

`default_nettype wire

[dv/udp_stream_chunk_deframer_checker.sv]
`default_nettype none

module udp_stream_chunk_deframer_checker
  import usd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic [7:0] in_data,
  input  wire logic       dg_valid,
  input  wire logic       dg_ready,
  input  wire logic [7:0] dg_byte,
  input  wire logic       dg_end,
  input  wire logic       dg_empty,
  output int              fail_count,
  output int              pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    PH_CHUNK_TYPE = 2'd0,
    PH_CHUNK_LEN  = 2'd1,
    PH_CHUNK_BODY = 2'd2
  } parse_phase_t;

  parse_phase_t      phase;
  logic [2:0]        varint_owed;
  logic [VALUE_W-1:0] varint_value;
  logic              skip_chunk;
  logic [VALUE_W-1:0] body_left;

  usd_result_t expected_dgrams[$];
  int          n_fail = 0;

  // Feeds one byte to the varint decoder; true once the varint is complete.
  function automatic bit take_varint_byte(input logic [7:0] b);
    if (varint_owed == 3'd0) begin
      varint_value = {{(VALUE_W-6){1'b0}}, b[5:0]};
      case (b[7:6])
        2'd0: varint_owed = 3'd0;
        2'd1: varint_owed = 3'd1;
        2'd2: varint_owed = 3'd3;
        default: varint_owed = 3'd7;
      endcase
    end else begin
      varint_value = {varint_value[VALUE_W-9:0], b};
      varint_owed = varint_owed - 3'd1;
    end
    return varint_owed == 3'd0;
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, output usd_result_t res);
    bit produced;
    bit last;
    produced = 1'b0;
    res = '0;
    case (phase)
      PH_CHUNK_LEN: begin
        if (take_varint_byte(b)) begin
          body_left = varint_value;
          varint_value = '0;
          if (body_left == '0) begin
            phase = PH_CHUNK_TYPE;
            // A type-0 chunk with no payload still signals one empty datagram.
            if (!skip_chunk) begin
              res.out_byte = 8'h00;
              res.end_of_datagram = 1'b1;
              res.empty_datagram = 1'b1;
              produced = 1'b1;
            end
          end else begin
            phase = PH_CHUNK_BODY;
          end
        end
      end
      PH_CHUNK_BODY: begin
        body_left = body_left - 1'b1;
        last = (body_left == '0);
        if (last) phase = PH_CHUNK_TYPE;
        if (!skip_chunk) begin
          res.out_byte = b;
          res.end_of_datagram = last;
          res.empty_datagram = 1'b0;
          produced = 1'b1;
        end
      end
      default: begin
        if (take_varint_byte(b)) begin
          skip_chunk = (varint_value != '0);
          varint_value = '0;
          phase = PH_CHUNK_LEN;
        end else begin
          phase = PH_CHUNK_TYPE;
        end
      end
    endcase
    return produced;
  endfunction

  always @(posedge clk) begin
    usd_result_t want;
    usd_result_t got;
    if (rst) begin
      phase = PH_CHUNK_TYPE;
      varint_owed = '0;
      varint_value = '0;
      skip_chunk = 1'b0;
      body_left = '0;
      expected_dgrams.delete();
    end else begin
      // A result never leaves in the cycle its byte arrives, so compare first.
      if (dg_valid && dg_ready) begin
        got.out_byte = dg_byte;
        got.end_of_datagram = dg_end;
        got.empty_datagram = dg_empty;
        if (expected_dgrams.size() == 0) begin
          $error("datagram request with nothing expected: out_byte %0h", got.out_byte);
          n_fail++;
        end else begin
          want = expected_dgrams.pop_front();
          if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, actual %0h", want.out_byte, got.out_byte);
            n_fail++;
          end
          if (got.end_of_datagram !== want.end_of_datagram) begin
            $error("end_of_datagram: expected %0b, actual %0b",
                   want.end_of_datagram, got.end_of_datagram);
            n_fail++;
          end
          if (got.empty_datagram !== want.empty_datagram) begin
            $error("empty_datagram: expected %0b, actual %0b",
                   want.empty_datagram, got.empty_datagram);
            n_fail++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (deframe_byte(in_data, want)) expected_dgrams.push_back(want);
      end
    end
    fail_count <= n_fail;
    pending_count <= expected_dgrams.size();
  end

endmodule

`default_nettype wire

[dv/udp_stream_chunk_deframer_test.sv]
`default_nettype none

module udp_stream_chunk_deframer_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst;
  bit   idle_on;
  int   fail_count;
  int   pending_count;

  logic [7:0] stream[$];

  usd_in_if  bytes_if();
  usd_out_if dgram_if();

  udp_stream_chunk_deframer u_dut (
    .clk(clk),
    .rst(rst),
    .bytes(bytes_if),
    .datagrams(dgram_if)
  );

  udp_stream_chunk_deframer_checker u_checker (
    .clk(clk),
    .rst(rst),
    .in_valid(bytes_if.valid),
    .in_ready(bytes_if.ready),
    .in_data(bytes_if.in_byte),
    .dg_valid(dgram_if.valid),
    .dg_ready(dgram_if.ready),
    .dg_byte(dgram_if.out_byte),
    .dg_end(dgram_if.end_of_datagram),
    .dg_empty(dgram_if.empty_datagram),
    .fail_count(fail_count),
    .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [1:0] shortest_code(input logic [61:0] v);
    if (v < 62'd64) return 2'd0;
    if (v < 62'd16384) return 2'd1;
    if (v < 62'd1073741824) return 2'd2;
    return 2'd3;
  endfunction

  // Appends v as a varint of 1 << code bytes; v must fit that size.
  task automatic push_varint(input logic [61:0] v, input logic [1:0] code);
    int         n;
    logic [63:0] w;
    logic [7:0] b;
    n = 1 << code;
    w = {2'b00, v};
    for (int i = n - 1; i >= 0; i--) begin
      b = w[8*i +: 8];
      if (i == n - 1) b[7:6] = code;
      stream.push_back(b);
    end
  endtask

  task automatic add_random_chunk();
    logic [61:0] typ;
    logic [61:0] len;
    logic [61:0] mask;
    logic [1:0]  tcode;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    tcode = 2'($urandom_range(0, 3));
    if (pick < 10) begin
      // Raw type bytes with arbitrary content.
      stream.push_back({tcode, 6'($urandom)});
      repeat ((1 << tcode) - 1) stream.push_back(8'($urandom));
    end else if (pick < 65) begin
      push_varint('0, tcode);
    end else begin
      mask = (62'd1 << (8 * (1 << tcode) - 2)) - 62'd1;
      typ = 62'({$urandom, $urandom}) & mask;
      if (typ == '0) typ = 62'd1;
      push_varint(typ, tcode);
    end
    pick = $urandom_range(0, 99);
    if (pick < 85) len = 62'($urandom_range(0, 12));
    else if (pick < 97) len = 62'($urandom_range(13, 64));
    else len = 62'($urandom_range(200, 400));
    push_varint(len, 2'($urandom_range(shortest_code(len), 3)));
    repeat (int'(len)) stream.push_back(8'($urandom));
  endtask

  task automatic drive_stream();
    for (int idx = 0; idx < stream.size(); idx++) begin
      if (idle_on && $urandom_range(0, 7) == 0) begin
        bytes_if.valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      bytes_if.valid <= 1'b1;
      bytes_if.in_byte <= stream[idx];
      @(posedge clk);
      while (!bytes_if.ready) @(posedge clk);
    end
    stream.delete();
  endtask

  task automatic wait_drained();
    bytes_if.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // Receiver side: random stall bursts while idling is enabled.
  initial begin
    int unsigned stall;
    stall = 0;
    dgram_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall != 0) begin
        dgram_if.ready <= 1'b0;
        stall--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        dgram_if.ready <= 1'b0;
        stall = $urandom_range(0, 9);
      end else begin
        dgram_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    rst = 1'b1;
    idle_on = 1'b1;
    bytes_if.valid = 1'b0;
    bytes_if.in_byte = 8'h00;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Empty type-0 chunk, then an empty chunk of another type.
    push_varint('0, 2'd0);
    push_varint('0, 2'd0);
    push_varint(62'd5, 2'd0);
    push_varint('0, 2'd0);
    // Short datagrams with extreme byte values.
    push_varint('0, 2'd0);
    push_varint(62'd1, 2'd0);
    stream.push_back(8'hff);
    push_varint('0, 2'd0);
    push_varint(62'd2, 2'd0);
    stream.push_back(8'h00);
    stream.push_back(8'h80);
    // Type 0 in the longest encoding, length in a two-byte one.
    push_varint('0, 2'd3);
    push_varint(62'd1, 2'd1);
    stream.push_back(8'h7e);
    // Dropped chunk with a payload.
    push_varint(62'h3f, 2'd0);
    push_varint(62'd1, 2'd0);
    stream.push_back(8'haa);
    drive_stream();
    wait_drained();

    for (int seg = 0; seg < 6; seg++) begin
      idle_on = (seg != 2) && (seg != 5);
      while (stream.size() < 300) add_random_chunk();
      drive_stream();
      if (seg == 3) wait_drained();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
